FILE: hdl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// shared types, character codes and the power-of-ten table for the decimal
// text to fixed-point converter
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 48;
  localparam int DIV_W     = 30;
  localparam int FCNT_W    = 4;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 56;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic snap;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [FCNT_W-1:0] k);
    logic [DIV_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/dtf_ctrl.sv
// ----------------------------------------------------------------------------
// dtf_ctrl
// sequencer: takes characters, runs the fraction divider one quotient bit per
// cycle after the last character, then hands the result to the output register
// ----------------------------------------------------------------------------
module dtf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  output logic             s_tready,
  input  dtf_pkg::status_t status,
  output dtf_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  dtf_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtf_pkg::ST_TAKE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      dtf_pkg::ST_TAKE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && s_tlast) begin
          cmd.snap   = 1'b1;
          cnt_next   = '0;
          state_next = dtf_pkg::ST_DIV;
        end
      end
      dtf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          state_next = dtf_pkg::ST_DONE;
        end
      end
      dtf_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = dtf_pkg::ST_TAKE;
        end
      end
      default: begin
        state_next = dtf_pkg::ST_TAKE;
      end
    endcase
  end

endmodule

FILE: hdl/dtf_dp.sv
// ----------------------------------------------------------------------------
// dtf_dp
// datapath: format check, integer and fraction accumulators, restoring
// fraction divider and the output register
// ----------------------------------------------------------------------------
module dtf_dp #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dtf_pkg::CHAR_W-1:0]          char_code,
  input  dtf_pkg::cmd_t                       cmd,
  output dtf_pkg::status_t                    status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic                                format_ok,
  output logic                                overflow,
  output logic [dtf_pkg::VALUE_W-1:0]         value
);

  localparam int DW = dtf_pkg::DIV_W;
  localparam int FW = dtf_pkg::FCNT_W;
  localparam int VW = dtf_pkg::VALUE_W;

  // token state
  logic                at_first, minus, point, bad, sat;
  logic [INT_BITS-1:0] int_acc;
  logic [DW-1:0]       frac_acc;
  logic [FW-1:0]       frac_cnt;

  logic                minus_next, point_next, bad_next, sat_next;
  logic [INT_BITS-1:0] int_next;
  logic [DW-1:0]       frac_next;
  logic [FW-1:0]       cnt_next;

  logic                is_digit;
  logic [3:0]          digit;
  logic [INT_BITS+3:0] int_mul;
  logic [DW-1:0]       frac_mul;

  // divider work registers
  logic [DW-1:0]        rem, divisor;
  logic [FRAC_BITS-1:0] quot;
  logic [INT_BITS-1:0]  w_int;
  logic                 w_minus, w_bad, w_sat;
  logic [DW:0]          trial;
  logic [DW:0]          trial_sub;

  logic [VW-1:0]        mag;

  assign is_digit = (char_code >= dtf_pkg::CHAR_ZERO) && (char_code <= dtf_pkg::CHAR_NINE);
  assign digit    = 4'(char_code - dtf_pkg::CHAR_ZERO);
  assign int_mul  = ((INT_BITS+4)'(int_acc) << 3) + ((INT_BITS+4)'(int_acc) << 1)
                    + (INT_BITS+4)'(digit);
  // at most nine fraction digits, so the product stays below 10^9
  assign frac_mul = (frac_acc << 3) + (frac_acc << 1) + DW'(digit);

  always_comb begin
    minus_next = minus;
    point_next = point;
    bad_next   = bad;
    sat_next   = sat;
    int_next   = int_acc;
    frac_next  = frac_acc;
    cnt_next   = frac_cnt;
    if (char_code == dtf_pkg::CHAR_MINUS) begin
      if (at_first) begin
        minus_next = 1'b1;
      end else begin
        bad_next = 1'b1;
      end
    end else if (char_code == dtf_pkg::CHAR_POINT) begin
      if (at_first || point) begin
        bad_next = 1'b1;
      end else begin
        point_next = 1'b1;
      end
    end else if (is_digit) begin
      if (!point) begin
        if (int_mul[INT_BITS+3:INT_BITS] != 4'd0) begin
          int_next = '1;
          sat_next = 1'b1;
        end else begin
          int_next = int_mul[INT_BITS-1:0];
        end
      end else if (frac_cnt < FW'(MAX_FRAC_DIGITS)) begin
        frac_next = frac_mul;
        cnt_next  = frac_cnt + 1'b1;
      end
    end else begin
      bad_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first <= 1'b1;
      minus    <= 1'b0;
      point    <= 1'b0;
      bad      <= 1'b0;
      sat      <= 1'b0;
      int_acc  <= '0;
      frac_acc <= '0;
      frac_cnt <= '0;
    end else if (cmd.take) begin
      if (cmd.snap) begin
        at_first <= 1'b1;
        minus    <= 1'b0;
        point    <= 1'b0;
        bad      <= 1'b0;
        sat      <= 1'b0;
        int_acc  <= '0;
        frac_acc <= '0;
        frac_cnt <= '0;
      end else begin
        at_first <= 1'b0;
        minus    <= minus_next;
        point    <= point_next;
        bad      <= bad_next;
        sat      <= sat_next;
        int_acc  <= int_next;
        frac_acc <= frac_next;
        frac_cnt <= cnt_next;
      end
    end
  end

  // restoring division, remainder always below the divisor
  assign trial     = {rem, 1'b0};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      rem     <= frac_next;
      divisor <= dtf_pkg::pow10(cnt_next);
      quot    <= '0;
      w_int   <= int_next;
      w_minus <= minus_next;
      w_bad   <= bad_next;
      w_sat   <= sat_next;
    end else if (cmd.div_step) begin
      if (!trial_sub[DW]) begin
        rem  <= trial_sub[DW-1:0];
        quot <= {quot[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem  <= trial[DW-1:0];
        quot <= {quot[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // quotient is below 2^FRAC_BITS, so the sum is a concatenation
  assign mag = VW'({w_int, quot});

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      format_ok <= !w_bad;
      overflow  <= !w_bad && w_sat;
      if (w_bad) begin
        value <= '0;
      end else if (w_minus) begin
        value <= VW'(0) - mag;
      end else begin
        value <= mag;
      end
    end
  end

endmodule

FILE: hdl/decimal_text_to_fixed.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed
// ascii decimal token to signed fixed point with FRAC_BITS fraction bits
// ----------------------------------------------------------------------------
// characters other than the last are taken at one beat per cycle
// after the last character the input stalls while the fraction divider produces
// one quotient bit per cycle, and then until the output register is free to take the result
// the result beat becomes valid once the divider has run and the output register is loaded
// the output register lets the next token stream in while a result waits
// rst clears the token state, the sequencer and the output valid flag
module decimal_text_to_fixed #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dtf_pkg::S_DATA_W-1:0]    s_tdata,   // [7:0] char_code
  input  logic                            s_tlast,   // is_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dtf_pkg::M_DATA_W-1:0]    m_tdata    // [0] format_ok, [1] overflow,
                                                     // [49:2] value, [55:50] zero
);

  dtf_pkg::cmd_t                  cmd;
  dtf_pkg::status_t               status;
  logic                           format_ok;
  logic                           overflow;
  logic [dtf_pkg::VALUE_W-1:0]    value;

  dtf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dtf_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .format_ok (format_ok),
    .overflow  (overflow),
    .value     (value)
  );

  assign m_tdata = {6'd0, value, overflow, format_ok};

endmodule

FILE: hdl/dtf_chk.sv
// ----------------------------------------------------------------------------
// dtf_chk
// port-level checks for the decimal text to fixed-point converter
// ----------------------------------------------------------------------------
module dtf_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dtf_pkg::M_DATA_W-1:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[49:1] == 49'd0)
    else $error("malformed token carries a non-zero value or overflow");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input not stalled for the fraction division");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:50] == 6'd0)
    else $error("result padding not zero");

endmodule

bind decimal_text_to_fixed dtf_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
